### hdl/stream_id_and_length_prefix_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef STREAM_ID_AND_LENGTH_PREFIX_DEFRAMER_DEFINES_SVH
`define STREAM_ID_AND_LENGTH_PREFIX_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define SIDF_CHECK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sidf check failed");

// Check that a condition in one cycle implies another in the next.
`define SIDF_CHECK_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("sidf check failed");

`else

`define SIDF_CHECK(label, prop)
`define SIDF_CHECK_NEXT(label, pre, post)

`endif

`endif

### hdl/sidf_pkg.sv
package sidf_pkg;

	localparam int ID_BYTES_DEF     = 16;
	localparam int HEADER_BYTES_DEF = 4;

	// Packed id output is always the full 16 bytes wide.
	localparam int ID_FULL_W = 128;
	localparam int ID_HALF_W = 64;
	localparam int LEN_W     = 32;
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [KIND_W-1:0] KIND_ABSORBED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SESSION  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TRACK    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SIGNAL   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MEDIA    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DATA     = 3'd5;
	localparam logic [KIND_W-1:0] KIND_REFUSED  = 3'd6;

	localparam logic ACT_STREAM = 1'b0;
	localparam logic ACT_ARM    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MEDIA_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SINK_PRESENT = 1'd1;

	typedef struct packed {
		logic media_mode;
		logic sink_present;
	} cfg_t;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] stream_byte;
		logic              chunk_end;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [BYTE_W-1:0]    out_byte;
		logic                 is_last;
		logic [ID_HALF_W-1:0] id_high;
		logic [ID_HALF_W-1:0] id_low;
		logic [LEN_W-1:0]     frame_length;
		logic                 piped;
	} result_t;

endpackage

### hdl/sidf_core.sv
`include "stream_id_and_length_prefix_deframer_defines.svh"

module sidf_core #(
	parameter int ID_BYTES     = sidf_pkg::ID_BYTES_DEF,
	parameter int HEADER_BYTES = sidf_pkg::HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sidf_pkg::item_t   item,
	input  sidf_pkg::cfg_t    cfg,
	output sidf_pkg::result_t res
);

	localparam int CntW = $clog2(ID_BYTES + 1);
	localparam int HdrW = $clog2(HEADER_BYTES + 1);
	localparam int IdW  = ID_BYTES * sidf_pkg::BYTE_W;
	localparam int LenW = sidf_pkg::LEN_W;
	localparam logic [CntW-1:0] ID_CNT  = CntW'(ID_BYTES);
	localparam logic [HdrW-1:0] HDR_CNT = HdrW'(HEADER_BYTES);

	// One id shift register serves both captures: the track id only starts
	// once the session id has been reported.
	logic [IdW-1:0]  id_q, id_d, id_next;
	logic [CntW-1:0] session_count_q, session_count_d;
	logic [CntW-1:0] track_count_q, track_count_d;
	logic            track_armed_q, track_armed_d;
	logic            piped_q, piped_d;
	logic            reading_header_q, reading_header_d;
	logic [HdrW-1:0] header_count_q, header_count_d;
	logic [LenW-1:0] length_q, length_d;
	logic [LenW-1:0] body_offset_q, body_offset_d;

	logic [sidf_pkg::ID_FULL_W-1:0] id_packed;
	logic                           hdr_eff;
	logic [HdrW-1:0]                hdr_cnt_inc;
	logic [LenW-1:0]                body_inc;

	always_comb begin
		id_d             = id_q;
		session_count_d  = session_count_q;
		track_count_d    = track_count_q;
		track_armed_d    = track_armed_q;
		piped_d          = piped_q;
		reading_header_d = reading_header_q;
		header_count_d   = header_count_q;
		length_d         = length_q;
		body_offset_d    = body_offset_q;
		res              = '0;

		id_next   = IdW'({id_q, item.stream_byte});
		id_packed = sidf_pkg::ID_FULL_W'(id_next) << (sidf_pkg::ID_FULL_W - IdW);

		// A fresh header starts when no frame is open.
		hdr_eff     = reading_header_q || (length_q == '0 && body_offset_q == '0);
		hdr_cnt_inc = (reading_header_q ? header_count_q : '0) + HdrW'(1);
		body_inc    = body_offset_q + LenW'(1);

		priority if (item.action == sidf_pkg::ACT_ARM) begin
			if (track_count_q < ID_CNT) begin
				track_armed_d = 1'b1;
			end
		end else if (session_count_q < ID_CNT) begin
			id_d            = id_next;
			session_count_d = session_count_q + CntW'(1);
			if (session_count_q + CntW'(1) == ID_CNT) begin
				piped_d     = piped_q | (|id_next);
				res.kind    = sidf_pkg::KIND_SESSION;
				res.id_high = id_packed[sidf_pkg::ID_FULL_W-1 -: sidf_pkg::ID_HALF_W];
				res.id_low  = id_packed[sidf_pkg::ID_HALF_W-1:0];
			end
		end else if (track_armed_q) begin
			id_d          = id_next;
			track_count_d = track_count_q + CntW'(1);
			if (track_count_q + CntW'(1) >= ID_CNT) begin
				track_armed_d = 1'b0;
				res.kind      = sidf_pkg::KIND_TRACK;
				res.id_high   = id_packed[sidf_pkg::ID_FULL_W-1 -: sidf_pkg::ID_HALF_W];
				res.id_low    = id_packed[sidf_pkg::ID_HALF_W-1:0];
			end
		end else if (!piped_q) begin
			res.kind     = sidf_pkg::KIND_SIGNAL;
			res.out_byte = item.stream_byte;
		end else if (!cfg.sink_present) begin
			res.kind = sidf_pkg::KIND_REFUSED;
		end else if (!cfg.media_mode) begin
			res.kind     = sidf_pkg::KIND_DATA;
			res.out_byte = item.stream_byte;
			res.is_last  = item.chunk_end;
		end else if (hdr_eff) begin
			// Shift the length in, most significant byte first.
			length_d = LenW'({length_q, item.stream_byte});
			if (hdr_cnt_inc >= HDR_CNT) begin
				reading_header_d = 1'b0;
				header_count_d   = '0;
			end else begin
				reading_header_d = 1'b1;
				header_count_d   = hdr_cnt_inc;
			end
		end else begin
			res.kind         = sidf_pkg::KIND_MEDIA;
			res.out_byte     = item.stream_byte;
			res.frame_length = length_q;
			if (body_inc >= length_q) begin
				res.is_last   = 1'b1;
				length_d      = '0;
				body_offset_d = '0;
			end else begin
				body_offset_d = body_inc;
			end
		end

		res.piped = piped_d;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			id_q <= id_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_count_q  <= '0;
			track_count_q    <= '0;
			track_armed_q    <= 1'b0;
			piped_q          <= 1'b0;
			reading_header_q <= 1'b0;
			header_count_q   <= '0;
			length_q         <= '0;
			body_offset_q    <= '0;
		end else if (step) begin
			session_count_q  <= session_count_d;
			track_count_q    <= track_count_d;
			track_armed_q    <= track_armed_d;
			piped_q          <= piped_d;
			reading_header_q <= reading_header_d;
			header_count_q   <= header_count_d;
			length_q         <= length_d;
			body_offset_q    <= body_offset_d;
		end
	end

	`SIDF_CHECK(hdr_count_only_in_header, header_count_q != '0 |-> reading_header_q)
	`SIDF_CHECK(track_follows_session, track_count_q != '0 |-> session_count_q == ID_CNT)

endmodule

### hdl/stream_id_and_length_prefix_deframer.sv
// An accepted beat waits in the input register and is worked into the result
// register when that register advances; its result is offered from there.
// Throughput: one beat per cycle while out_ready stays high; while a result
// waits, the input register takes one more beat and then in_ready drops.
// Reset: arst_n clears all counters, flags, frame state and both config
// registers at once; the id shift register holds no reset and needs no clear.
`include "stream_id_and_length_prefix_deframer_defines.svh"

module stream_id_and_length_prefix_deframer #(
	parameter int ID_BYTES     = sidf_pkg::ID_BYTES_DEF,
	parameter int HEADER_BYTES = sidf_pkg::HEADER_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// Configuration write port
	input  logic                              cfg_wr_en,
	input  logic [sidf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic                              cfg_wdata,

	// Input beats
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [sidf_pkg::BYTE_W-1:0]       stream_byte,
	input  logic                              chunk_end,

	// Result beats
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sidf_pkg::KIND_W-1:0]       kind,
	output logic [sidf_pkg::BYTE_W-1:0]       out_byte,
	output logic                              is_last,
	output logic [sidf_pkg::ID_HALF_W-1:0]    id_high,
	output logic [sidf_pkg::ID_HALF_W-1:0]    id_low,
	output logic [sidf_pkg::LEN_W-1:0]        frame_length,
	output logic                              piped
);

	sidf_pkg::cfg_t    cfg_q;
	sidf_pkg::item_t   item_s1;
	logic              valid_s1;
	sidf_pkg::result_t res_comb;
	sidf_pkg::result_t res_s2;
	logic              valid_s2;
	logic              adv_s2;
	logic              step;

	// Config registers: the user must write them only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sidf_pkg::REG_MEDIA_MODE:   cfg_q.media_mode   <= cfg_wdata;
				sidf_pkg::REG_SINK_PRESENT: cfg_q.sink_present <= cfg_wdata;
				default:                    cfg_q              <= cfg_q;
			endcase
		end
	end

	// The result register advances when empty or when its beat is taken;
	// the input register advances into it in the same cycle.
	assign adv_s2   = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the input beat payload until it moves on.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action      <= action;
			item_s1.stream_byte <= stream_byte;
			item_s1.chunk_end   <= chunk_end;
		end
	end

	// All per-beat decisions: id capture, signaling, refusal, data and
	// length-prefixed frame parsing. State advances only on step.
	sidf_core #(
		.ID_BYTES     (ID_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid    = valid_s2;
	assign kind         = res_s2.kind;
	assign out_byte     = res_s2.out_byte;
	assign is_last      = res_s2.is_last;
	assign id_high      = res_s2.id_high;
	assign id_low       = res_s2.id_low;
	assign frame_length = res_s2.frame_length;
	assign piped        = res_s2.piped;

	`SIDF_CHECK_NEXT(step_loads_result, step, valid_s2)
	`SIDF_CHECK(signal_only_unpiped, valid_s2 && kind == sidf_pkg::KIND_SIGNAL |-> !piped)
	`SIDF_CHECK(media_has_length, valid_s2 && kind == sidf_pkg::KIND_MEDIA |-> frame_length != '0)
	`SIDF_CHECK(last_only_on_payload, valid_s2 && is_last |-> kind == sidf_pkg::KIND_MEDIA || kind == sidf_pkg::KIND_DATA)

endmodule

### tb/sv/tb_stream_id_and_length_prefix_deframer.sv
`timescale 1ns / 1ps

// Tracks the deframer's state beat by beat and holds the results it must produce.
class deframer_scoreboard;
	sidf_pkg::result_t expected_results[$];
	logic [7:0]  session_bytes[16];
	logic [7:0]  track_bytes[16];
	int unsigned session_fill = 0;
	int unsigned track_fill = 0;
	int unsigned header_fill = 0;
	bit          track_armed = 0;
	bit          piped_flag = 0;
	bit          in_header = 0;
	bit          media_mode = 0;
	bit          sink_present = 0;
	logic [31:0] frame_len = '0;
	logic [31:0] body_pos = '0;
	int unsigned mismatches = 0;
	int unsigned beats_noted = 0;
	int unsigned kind_hits[8];

	function new();
		foreach (kind_hits[i])
			kind_hits[i] = 0;
	endfunction

	function void set_reg(logic [sidf_pkg::CFG_IDX_W-1:0] idx, logic val);
		if (idx == sidf_pkg::REG_MEDIA_MODE)
			media_mode = val;
		else if (idx == sidf_pkg::REG_SINK_PRESENT)
			sink_present = val;
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	function logic [127:0] pack_id(logic [7:0] ids[16]);
		logic [127:0] acc;
		acc = '0;
		for (int i = 0; i < 16; i++)
			acc = {acc[119:0], (i < sidf_pkg::ID_BYTES_DEF) ? ids[i] : 8'h00};
		return acc;
	endfunction

	// Advance the state by one beat and queue the result it causes.
	function void note_beat(sidf_pkg::item_t it);
		sidf_pkg::result_t r;
		logic [127:0]      id;
		r = '0;
		r.kind = sidf_pkg::KIND_ABSORBED;
		beats_noted++;
		if (it.action == sidf_pkg::ACT_ARM) begin
			if (track_fill < sidf_pkg::ID_BYTES_DEF)
				track_armed = 1;
		end else if (session_fill < sidf_pkg::ID_BYTES_DEF) begin
			session_bytes[4'(session_fill)] = it.stream_byte;
			session_fill++;
			if (session_fill == sidf_pkg::ID_BYTES_DEF) begin
				for (int i = 0; i < sidf_pkg::ID_BYTES_DEF; i++)
					if (session_bytes[i] != 8'h00)
						piped_flag = 1;
				id = pack_id(session_bytes);
				r.id_high = id[127:64];
				r.id_low  = id[63:0];
				r.kind    = sidf_pkg::KIND_SESSION;
			end
		end else if (track_armed) begin
			track_bytes[4'(track_fill)] = it.stream_byte;
			track_fill++;
			if (track_fill >= sidf_pkg::ID_BYTES_DEF) begin
				track_armed = 0;
				id = pack_id(track_bytes);
				r.id_high = id[127:64];
				r.id_low  = id[63:0];
				r.kind    = sidf_pkg::KIND_TRACK;
			end
		end else if (!piped_flag) begin
			r.kind     = sidf_pkg::KIND_SIGNAL;
			r.out_byte = it.stream_byte;
		end else if (!sink_present) begin
			r.kind = sidf_pkg::KIND_REFUSED;
		end else if (!media_mode) begin
			r.kind     = sidf_pkg::KIND_DATA;
			r.out_byte = it.stream_byte;
			r.is_last  = it.chunk_end;
		end else begin
			if (!in_header && frame_len == 0 && body_pos == 0) begin
				in_header   = 1;
				header_fill = 0;
			end
			if (in_header) begin
				frame_len = {frame_len[23:0], it.stream_byte};
				header_fill++;
				if (header_fill >= sidf_pkg::HEADER_BYTES_DEF) begin
					in_header   = 0;
					header_fill = 0;
				end
			end else begin
				r.kind         = sidf_pkg::KIND_MEDIA;
				r.out_byte     = it.stream_byte;
				r.frame_length = frame_len;
				body_pos++;
				if (body_pos >= frame_len) begin
					r.is_last = 1;
					frame_len = '0;
					body_pos  = '0;
				end
			end
		end
		r.piped = piped_flag;
		expected_results.push_back(r);
	endfunction

	function void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
		mismatches++;
	endfunction

	function void check_result(sidf_pkg::result_t got);
		sidf_pkg::result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result, expected none actual kind %0d byte %0h",
				$time, got.kind, got.out_byte);
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		kind_hits[got.kind]++;
		if (got.kind !== want.kind)
			note_mismatch("kind", 64'(want.kind), 64'(got.kind));
		if (got.out_byte !== want.out_byte)
			note_mismatch("out_byte", 64'(want.out_byte), 64'(got.out_byte));
		if (got.is_last !== want.is_last)
			note_mismatch("is_last", 64'(want.is_last), 64'(got.is_last));
		if (got.id_high !== want.id_high)
			note_mismatch("id_high", want.id_high, got.id_high);
		if (got.id_low !== want.id_low)
			note_mismatch("id_low", want.id_low, got.id_low);
		if (got.frame_length !== want.frame_length)
			note_mismatch("frame_length", 64'(want.frame_length), 64'(got.frame_length));
		if (got.piped !== want.piped)
			note_mismatch("piped", 64'(want.piped), 64'(got.piped));
	endfunction
endclass

module tb_stream_id_and_length_prefix_deframer;

	// Generous bound: ~700 beats, some phases with long sender gaps and receiver stalls.
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_wr_en;
	logic [sidf_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic                                cfg_wdata;
	logic                                in_valid;
	logic                                in_ready;
	logic                                action;
	logic [sidf_pkg::BYTE_W-1:0]         stream_byte;
	logic                                chunk_end;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [sidf_pkg::KIND_W-1:0]         kind;
	logic [sidf_pkg::BYTE_W-1:0]         out_byte;
	logic                                is_last;
	logic [sidf_pkg::ID_HALF_W-1:0]      id_high;
	logic [sidf_pkg::ID_HALF_W-1:0]      id_low;
	logic [sidf_pkg::LEN_W-1:0]          frame_length;
	logic                                piped;

	sidf_pkg::item_t   seen_item;
	sidf_pkg::result_t seen_result;

	deframer_scoreboard sb = new();

	// Percent chance per cycle that the sender holds off or the receiver stalls.
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	// Media framing shaper: header bytes still to send, body bytes still owed.
	int          hdr_left = 0;
	int unsigned body_left = 0;
	logic [31:0] next_len = '0;

	int unsigned cycle_count = 0;

	stream_id_and_length_prefix_deframer dut (.*);

	always #1 clk = ~clk;

	assign seen_item   = {action, stream_byte, chunk_end};
	assign seen_result = {kind, out_byte, is_last, id_high, id_low, frame_length, piped};

	// Sample both handshakes on the edge itself; values read here are pre-edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_beat(seen_item);
			if (out_valid && out_ready)
				sb.check_result(seen_result);
		end
	end

	// Receiver back-pressure, re-rolled every cycle.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= sink_stall_pct);

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending());
			$display("stream_id_and_length_prefix_deframer verification failed");
			$finish;
		end
	end

	// Drop valid and wait until every queued result has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Offer one beat and hold it until the block takes it. Returns on the
	// accepting edge, so the next call may present a new beat with valid kept high.
	task automatic push_beat(logic act, logic [7:0] b, logic ce);
		// Rarely hold off entirely until every outstanding result has drained.
		if ($urandom_range(199) == 0)
			drain_results();
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		stream_byte <= b;
		chunk_end   <= ce;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_config(logic mm, logic sp);
		cfg_wr_en <= 1'b1;
		cfg_index <= sidf_pkg::REG_MEDIA_MODE;
		cfg_wdata <= mm;
		sb.set_reg(sidf_pkg::REG_MEDIA_MODE, mm);
		@(posedge clk);
		cfg_index <= sidf_pkg::REG_SINK_PRESENT;
		cfg_wdata <= sp;
		sb.set_reg(sidf_pkg::REG_SINK_PRESENT, sp);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Change registers only with the block idle.
	task automatic reconfigure(logic mm, logic sp);
		drain_results();
		repeat (3) @(posedge clk);
		write_config(mm, sp);
	endtask

	task automatic push_header(logic [31:0] len);
		for (int i = sidf_pkg::HEADER_BYTES_DEF - 1; i >= 0; i--)
			push_beat(sidf_pkg::ACT_STREAM, len[8*i +: 8], 1'($urandom_range(1)));
	endtask

	// Emit the next byte of a well-formed frame stream; mostly short frames,
	// some empty ones, a few long ones.
	task automatic media_beat();
		int pick;
		if (hdr_left == 0 && body_left == 0) begin
			pick = $urandom_range(99);
			if (pick < 12)
				next_len = 0;
			else if (pick < 80)
				next_len = $urandom_range(6, 1);
			else if (pick < 97)
				next_len = $urandom_range(40, 7);
			else
				next_len = $urandom_range(300, 41);
			hdr_left = sidf_pkg::HEADER_BYTES_DEF;
		end
		if (hdr_left > 0) begin
			push_beat(sidf_pkg::ACT_STREAM, next_len[8*hdr_left-1 -: 8],
				1'($urandom_range(1)));
			hdr_left--;
			if (hdr_left == 0)
				body_left = next_len;
		end else begin
			push_beat(sidf_pkg::ACT_STREAM, 8'($urandom_range(255)), 1'($urandom_range(1)));
			body_left--;
		end
	endtask

	// One random phase under a fixed register setting and idling mix.
	// Stray arm beats are sprinkled in; they are ignored and not counted.
	task automatic run_phase(logic mm, logic sp, int src_pct, int sink_pct, int beats);
		int sent;
		sent = 0;
		reconfigure(mm, sp);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		while (sent < beats) begin
			if ($urandom_range(99) < 3) begin
				push_beat(sidf_pkg::ACT_ARM, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end else begin
				if (mm && sp)
					media_beat();
				else
					push_beat(sidf_pkg::ACT_STREAM, 8'($urandom_range(255)),
						$urandom_range(3) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_index   <= sidf_pkg::REG_MEDIA_MODE;
		cfg_wdata   <= 1'b0;
		in_valid    <= 1'b0;
		action      <= sidf_pkg::ACT_STREAM;
		stream_byte <= '0;
		chunk_end   <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_config(1'b0, 1'b0);

		// Session id: mostly zero bytes with two 0xFF, so the stream is piped.
		// Arm halfway through; the track id must follow the session id.
		for (int i = 0; i < sidf_pkg::ID_BYTES_DEF; i++) begin
			if (i == sidf_pkg::ID_BYTES_DEF / 2)
				push_beat(sidf_pkg::ACT_ARM, 8'hFF, 1'b1);
			push_beat(sidf_pkg::ACT_STREAM, (i == 3 || i == 12) ? 8'hFF : 8'h00, i[0]);
		end
		// Track id: random content, bounded by the all-ones and all-zero bytes.
		for (int i = 0; i < sidf_pkg::ID_BYTES_DEF; i++)
			push_beat(sidf_pkg::ACT_STREAM, (i == 0) ? 8'hFF :
				(i == sidf_pkg::ID_BYTES_DEF - 1) ? 8'h00 : 8'($urandom_range(255)), i[0]);
		// Repeat arm after the track id is complete: ignored.
		push_beat(sidf_pkg::ACT_ARM, 8'h00, 1'b0);
		// No sink attached: piped byte refused.
		push_beat(sidf_pkg::ACT_STREAM, 8'h33, 1'b1);

		// Data mode pass-through with and without the chunk end mark.
		reconfigure(1'b0, 1'b1);
		push_beat(sidf_pkg::ACT_STREAM, 8'h00, 1'b0);
		push_beat(sidf_pkg::ACT_STREAM, 8'hFF, 1'b1);

		// Media: empty frame dropped, one-byte frame, then a frame interrupted
		// by a switch to data mode and resumed afterwards.
		reconfigure(1'b1, 1'b1);
		push_header(32'd0);
		push_header(32'd1);
		push_beat(sidf_pkg::ACT_STREAM, 8'hAB, 1'b0);
		push_header(32'd3);
		push_beat(sidf_pkg::ACT_STREAM, 8'h11, 1'b0);
		reconfigure(1'b0, 1'b1);
		push_beat(sidf_pkg::ACT_STREAM, 8'h77, 1'b1);
		reconfigure(1'b1, 1'b1);
		push_beat(sidf_pkg::ACT_STREAM, 8'h22, 1'b1);
		push_beat(sidf_pkg::ACT_STREAM, 8'h33, 1'b0);

		// Random phases: each idling mix, and every register setting except both off.
		run_phase(1'b1, 1'b1,  0,  0, 100);
		run_phase(1'b1, 1'b1, 87,  0,  80);
		run_phase(1'b0, 1'b1,  0, 87,  80);
		run_phase(1'b1, 1'b1, 17, 17,  80);
		run_phase(1'b1, 1'b0, 87,  0,  40);
		run_phase(1'b0, 1'b1, 17, 17,  60);
		run_phase(1'b1, 1'b1,  0, 87,  80);
		run_phase(1'b1, 1'b1,  0,  0,  70);

		// Close the open frame, then start one of the largest possible length.
		while (hdr_left != 0 || body_left != 0)
			media_beat();
		push_header(32'hFFFF_FFFF);
		repeat (3)
			push_beat(sidf_pkg::ACT_STREAM, 8'($urandom_range(255)), 1'b1);
		push_beat(sidf_pkg::ACT_ARM, 8'h5A, 1'b0);

		drain_results();
		repeat (8) @(posedge clk);

		$display("covered %0d input beats across 8 random phases plus directed framing cases",
			sb.beats_noted);
		$display("results seen: absorbed %0d session %0d track %0d media %0d data %0d refused %0d",
			sb.kind_hits[sidf_pkg::KIND_ABSORBED], sb.kind_hits[sidf_pkg::KIND_SESSION],
			sb.kind_hits[sidf_pkg::KIND_TRACK], sb.kind_hits[sidf_pkg::KIND_MEDIA],
			sb.kind_hits[sidf_pkg::KIND_DATA], sb.kind_hits[sidf_pkg::KIND_REFUSED]);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("stream_id_and_length_prefix_deframer verification clean");
		else
			$display("stream_id_and_length_prefix_deframer verification failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/sidf_pkg.sv
hdl/sidf_core.sv
hdl/stream_id_and_length_prefix_deframer.sv
tb/sv/tb_stream_id_and_length_prefix_deframer.sv
